FILE: design/cfa_pkg.sv
package cfa_pkg;

	// Operation codes carried in s_axis_tuser
	typedef enum logic [2:0] {
		CMD_ADD = 3'd0,
		CMD_SUB = 3'd1,
		CMD_MUL = 3'd2,
		CMD_DIV = 3'd3,
		CMD_EQ  = 3'd4,
		CMD_NE  = 3'd5
	} cmd_t;

	// How the final stage forms the result parts
	typedef enum logic [1:0] {
		MODE_ZERO = 2'd0,
		MODE_SAT  = 2'd1,
		MODE_DIV  = 2'd2
	} mode_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_SAT  = 2'd1;
	localparam logic [1:0] ST_DIV0 = 2'd2;

endpackage

FILE: design/complex_fixed_point_alu.sv
// Complex ALU on signed fixed point (DATA_WIDTH bits per part, FRAC_BITS of
// them fraction; Q8.8 by default). Each input word carries two complex
// operands in s_axis_tdata and the operation code in s_axis_tuser: add,
// subtract, multiply, divide (a * conj(b) / |b|^2), equal, not equal. One
// result word comes out per input word, in order. Results that leave the
// range clamp to the nearest limit with status 1; a zero divisor gives zero
// parts and status 2; compares return truth with zero parts. The block is a
// fully pipelined datapath: a new word can enter every clock unless
// back-pressure holds the pipeline full. A word passes through four front
// stages (operand register, products, product sums, divider setup), one
// restoring divider stage per quotient bit, and the saturating output
// register. Every stage holds its own valid bit, so back-pressure on the
// output stalls only the stages that are full and bubbles keep closing up.
module complex_fixed_point_alu #(
	parameter int DATA_WIDTH = 16,
	parameter int FRAC_BITS  = 8
) (
	input  logic clk,
	input  logic arst_n,

	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// a_re, a_im, b_re, b_im from the lowest bit up, zero padded
	input  logic [((4 * DATA_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
	// cmd
	input  logic [2:0]           s_axis_tuser,

	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// res_re, res_im from the lowest bit up, zero padded
	output logic [((2 * DATA_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,
	// truth, status from the lowest bit up
	output logic [2:0]           m_axis_tuser
);

	localparam int W         = DATA_WIDTH;
	localparam int P         = 2 * W + 1;
	localparam int OUT_BYTES = (2 * DATA_WIDTH + 7) / 8;
	// side payload: mode, truth, status, neg[2], ovf[2], pre[2]
	localparam int SW        = 2 + 1 + 2 + 2 + 2 + 2 * P;

	// front end to divider chain
	cfa_pkg::mode_t       f_mode;
	logic                 f_truth;
	logic [1:0]           f_status;
	logic [1:0]           f_neg, f_ovf;
	logic [1:0][P-1:0]    f_pre;

	// divider chain: index 0 is the front end output, index W the last step
	logic [W:0]                  c_valid, c_ready;
	logic [W:0][2*W-1:0]         c_den;
	logic [W:0][1:0][2*W-1:0]    c_rem;
	logic [W:0][1:0][W-1:0]      c_dvd;
	logic [W:0][1:0][W-1:0]      c_quo;
	logic [W:0][SW-1:0]          c_side;

	cfa_front #(
		.W (W),
		.F (FRAC_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_cmd     (s_axis_tuser),
		.in_a_re    (s_axis_tdata[W-1:0]),
		.in_a_im    (s_axis_tdata[2*W-1:W]),
		.in_b_re    (s_axis_tdata[3*W-1:2*W]),
		.in_b_im    (s_axis_tdata[4*W-1:3*W]),
		.out_valid  (c_valid[0]),
		.out_ready  (c_ready[0]),
		.out_mode   (f_mode),
		.out_truth  (f_truth),
		.out_status (f_status),
		.out_den    (c_den[0]),
		.out_neg    (f_neg),
		.out_ovf    (f_ovf),
		.out_rem    (c_rem[0]),
		.out_dvd    (c_dvd[0]),
		.out_pre    (f_pre)
	);

	assign c_quo[0]  = '0;
	assign c_side[0] = {f_pre, f_ovf, f_neg, f_status, f_truth, f_mode};

	// one quotient bit per stage, both parts side by side
	for (genvar g = 0; g < W; g++) begin : g_div
		cfa_div_stage #(
			.W  (W),
			.SW (SW)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (c_valid[g]),
			.in_ready  (c_ready[g]),
			.in_den    (c_den[g]),
			.in_rem    (c_rem[g]),
			.in_dvd    (c_dvd[g]),
			.in_quo    (c_quo[g]),
			.in_side   (c_side[g]),
			.out_valid (c_valid[g+1]),
			.out_ready (c_ready[g+1]),
			.out_den   (c_den[g+1]),
			.out_rem   (c_rem[g+1]),
			.out_dvd   (c_dvd[g+1]),
			.out_quo   (c_quo[g+1]),
			.out_side  (c_side[g+1])
		);
	end

	// unpack the side payload at the end of the chain
	cfa_pkg::mode_t       e_mode;
	logic                 e_truth;
	logic [1:0]           e_status;
	logic [1:0]           e_neg, e_ovf;
	logic [1:0][P-1:0]    e_pre;

	assign {e_pre, e_ovf, e_neg, e_status, e_truth} = c_side[W][SW-1:2];
	assign e_mode = cfa_pkg::mode_t'(c_side[W][1:0]);

	// final value before clamping, then saturation to the signed part range
	localparam logic signed [P-1:0] MAX_V = P'((64'd1 << (W - 1)) - 64'd1);
	localparam logic signed [P-1:0] MIN_V = -P'(64'd1 << (W - 1));

	logic signed [1:0][P-1:0] val;
	logic [P-1:0]             mag_v;
	logic [1:0][W-1:0]        res_c;
	logic [1:0]               clip_c;

	always_comb begin
		for (int k = 0; k < 2; k++) begin
			// an overflowed quotient stands in as 2^W, past either limit
			mag_v  = e_ovf[k] ? (P'(1) << W) : P'(c_quo[W][k]);
			val[k] = (e_mode == cfa_pkg::MODE_DIV) ? (e_neg[k] ? -mag_v : mag_v) : e_pre[k];
			clip_c[k] = 1'b0;
			if ($signed(val[k]) > MAX_V) begin
				res_c[k]  = MAX_V[W-1:0];
				clip_c[k] = 1'b1;
			end else if ($signed(val[k]) < MIN_V) begin
				res_c[k]  = MIN_V[W-1:0];
				clip_c[k] = 1'b1;
			end else begin
				res_c[k] = val[k][W-1:0];
			end
		end
	end

	// output register
	logic       out_v_q;
	logic       out_adv;
	logic [W-1:0] res_re_q, res_im_q;
	logic       truth_q;
	logic [1:0] status_q;

	assign out_adv   = !out_v_q || m_axis_tready;
	assign c_ready[W] = out_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_adv) begin
			out_v_q <= c_valid[W];
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv) begin
			case (e_mode)
				cfa_pkg::MODE_SAT, cfa_pkg::MODE_DIV: begin
					res_re_q <= res_c[0];
					res_im_q <= res_c[1];
					truth_q  <= 1'b0;
					status_q <= (|clip_c) ? cfa_pkg::ST_SAT : cfa_pkg::ST_OK;
				end
				default: begin
					// compares, zero divisor and unknown codes: zero parts
					res_re_q <= '0;
					res_im_q <= '0;
					truth_q  <= e_truth;
					status_q <= e_status;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = (OUT_BYTES*8)'({res_im_q, res_re_q});
	assign m_axis_tuser  = {status_q, truth_q};

endmodule

FILE: design/cfa_front.sv
module cfa_front #(
	parameter int W = 16,
	parameter int F = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [2:0]            in_cmd,
	input  logic [W-1:0]          in_a_re,
	input  logic [W-1:0]          in_a_im,
	input  logic [W-1:0]          in_b_re,
	input  logic [W-1:0]          in_b_im,
	output logic                  out_valid,
	input  logic                  out_ready,
	output cfa_pkg::mode_t        out_mode,
	output logic                  out_truth,
	output logic [1:0]            out_status,
	output logic [2*W-1:0]        out_den,
	output logic [1:0]            out_neg,
	output logic [1:0]            out_ovf,
	output logic [1:0][2*W-1:0]   out_rem,
	output logic [1:0][W-1:0]     out_dvd,
	output logic [1:0][2*W:0]     out_pre
);

	localparam int P  = 2 * W + 1;
	localparam int DW = 2 * W + F;

	logic v_s1, v_s2, v_s3, v_s4;
	logic adv1, adv2, adv3, adv4;

	// stage 1: operand register
	cfa_pkg::cmd_t         cmd_s1;
	logic signed [W-1:0]   ar_s1, ai_s1, br_s1, bi_s1;

	// stage 2: products, sums, compare
	cfa_pkg::cmd_t         cmd_s2;
	logic signed [2*W-1:0] rr_s2, ii_s2, ri_s2, ir_s2, bb_r_s2, bb_i_s2;
	logic signed [W:0]     sre_s2, sim_s2;
	logic                  eq_s2;

	// stage 3: combined products
	cfa_pkg::cmd_t         cmd_s3;
	logic signed [P-1:0]   pre_re_s3, pre_im_s3;
	logic [2*W-1:0]        den_s3;
	logic                  eq_s3;

	// stage 3 combinational
	logic signed [P-1:0]   rr_x, ii_x, ri_x, ir_x, mre, mim;
	logic signed [W:0]     sum_re, sum_im;
	logic signed [P-1:0]   pre_re_s3_d, pre_im_s3_d;

	// stage 4 combinational
	logic [1:0]            neg_c, ovf_c;
	logic [1:0][2*W-1:0]   mag_c, rem_c;
	logic [1:0][W-1:0]     dvd_c;
	logic [1:0][DW-1:0]    dend_c;
	logic [1:0][P-1:0]     pre_c;

	assign adv4     = !v_s4 || out_ready;
	assign adv3     = !v_s3 || adv4;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;
	assign out_valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			cmd_s1 <= cfa_pkg::cmd_t'(in_cmd);
			ar_s1  <= in_a_re;
			ai_s1  <= in_a_im;
			br_s1  <= in_b_re;
			bi_s1  <= in_b_im;
		end
	end

	always_comb begin
		if (cmd_s1 == cfa_pkg::CMD_SUB) begin
			sum_re = {ar_s1[W-1], ar_s1} - {br_s1[W-1], br_s1};
			sum_im = {ai_s1[W-1], ai_s1} - {bi_s1[W-1], bi_s1};
		end else begin
			sum_re = {ar_s1[W-1], ar_s1} + {br_s1[W-1], br_s1};
			sum_im = {ai_s1[W-1], ai_s1} + {bi_s1[W-1], bi_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			cmd_s2  <= cmd_s1;
			rr_s2   <= ar_s1 * br_s1;
			ii_s2   <= ai_s1 * bi_s1;
			ri_s2   <= ar_s1 * bi_s1;
			ir_s2   <= ai_s1 * br_s1;
			bb_r_s2 <= br_s1 * br_s1;
			bb_i_s2 <= bi_s1 * bi_s1;
			sre_s2  <= sum_re;
			sim_s2  <= sum_im;
			eq_s2   <= (ar_s1 == br_s1) && (ai_s1 == bi_s1);
		end
	end

	always_comb begin
		rr_x = {rr_s2[2*W-1], rr_s2};
		ii_x = {ii_s2[2*W-1], ii_s2};
		ri_x = {ri_s2[2*W-1], ri_s2};
		ir_x = {ir_s2[2*W-1], ir_s2};
		mre  = rr_x - ii_x;
		mim  = ri_x + ir_x;
		case (cmd_s2)
			cfa_pkg::CMD_MUL: begin
				pre_re_s3_d = mre >>> F;
				pre_im_s3_d = mim >>> F;
			end
			cfa_pkg::CMD_DIV: begin
				pre_re_s3_d = rr_x + ii_x;
				pre_im_s3_d = ir_x - ri_x;
			end
			default: begin
				pre_re_s3_d = {{(P-W-1){sre_s2[W]}}, sre_s2};
				pre_im_s3_d = {{(P-W-1){sim_s2[W]}}, sim_s2};
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			cmd_s3    <= cmd_s2;
			pre_re_s3 <= pre_re_s3_d;
			pre_im_s3 <= pre_im_s3_d;
			den_s3    <= bb_r_s2 + bb_i_s2;
			eq_s3     <= eq_s2;
		end
	end

	// stage 4: sign and magnitude, dividend split, overflow test
	always_comb begin
		pre_c[0] = pre_re_s3;
		pre_c[1] = pre_im_s3;
		for (int k = 0; k < 2; k++) begin
			neg_c[k]  = pre_c[k][P-1];
			mag_c[k]  = neg_c[k] ? (2*W)'(-pre_c[k]) : pre_c[k][2*W-1:0];
			dend_c[k] = {mag_c[k], {F{1'b0}}};
			ovf_c[k]  = (DW'(dend_c[k][DW-1:W]) >= DW'(den_s3));
			rem_c[k]  = (2*W)'(dend_c[k][DW-1:W]);
			dvd_c[k]  = dend_c[k][W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv4) begin
			out_den    <= den_s3;
			out_neg    <= neg_c;
			out_ovf    <= ovf_c;
			out_rem    <= rem_c;
			out_dvd    <= dvd_c;
			out_pre    <= pre_c;
			out_truth  <= 1'b0;
			out_status <= cfa_pkg::ST_OK;
			case (cmd_s3)
				cfa_pkg::CMD_ADD, cfa_pkg::CMD_SUB, cfa_pkg::CMD_MUL: begin
					out_mode <= cfa_pkg::MODE_SAT;
				end
				cfa_pkg::CMD_DIV: begin
					if (den_s3 == '0) begin
						out_mode   <= cfa_pkg::MODE_ZERO;
						out_status <= cfa_pkg::ST_DIV0;
					end else begin
						out_mode <= cfa_pkg::MODE_DIV;
					end
				end
				cfa_pkg::CMD_EQ: begin
					out_mode  <= cfa_pkg::MODE_ZERO;
					out_truth <= eq_s3;
				end
				cfa_pkg::CMD_NE: begin
					out_mode  <= cfa_pkg::MODE_ZERO;
					out_truth <= !eq_s3;
				end
				default: begin
					out_mode <= cfa_pkg::MODE_ZERO;
				end
			endcase
		end
	end

endmodule

FILE: design/cfa_div_stage.sv
module cfa_div_stage #(
	parameter int W  = 16,
	parameter int SW = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [2*W-1:0]       in_den,
	input  logic [1:0][2*W-1:0]  in_rem,
	input  logic [1:0][W-1:0]    in_dvd,
	input  logic [1:0][W-1:0]    in_quo,
	input  logic [SW-1:0]        in_side,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2*W-1:0]       out_den,
	output logic [1:0][2*W-1:0]  out_rem,
	output logic [1:0][W-1:0]    out_dvd,
	output logic [1:0][W-1:0]    out_quo,
	output logic [SW-1:0]        out_side
);

	logic                 v_q;
	logic                 adv;
	logic [1:0][2*W:0]    shl;
	logic [1:0][2*W-1:0]  rem_n;
	logic [1:0]           bit_n;

	assign adv       = !v_q || out_ready;
	assign in_ready  = adv;
	assign out_valid = v_q;

	// one restoring step per lane: shift in the next dividend bit, subtract if it fits
	always_comb begin
		for (int k = 0; k < 2; k++) begin
			shl[k]   = {in_rem[k], in_dvd[k][W-1]};
			bit_n[k] = (shl[k] >= {1'b0, in_den});
			rem_n[k] = bit_n[k] ? (2*W)'(shl[k] - {1'b0, in_den}) : shl[k][2*W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (adv) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_den  <= in_den;
			out_side <= in_side;
			for (int k = 0; k < 2; k++) begin
				out_rem[k] <= rem_n[k];
				out_dvd[k] <= {in_dvd[k][W-2:0], 1'b0};
				out_quo[k] <= {in_quo[k][W-2:0], bit_n[k]};
			end
		end
	end

endmodule

FILE: test/tb_complex_fixed_point_alu.sv
`timescale 1ns / 1ps

module tb_complex_fixed_point_alu;

	localparam int DW       = 16;
	localparam int FB       = 8;
	localparam int MAX_CYC  = 300000;
	localparam longint PMAX = (64'sd1 <<< (DW - 1)) - 1;
	localparam longint NMIN = -(64'sd1 <<< (DW - 1));

	typedef struct packed {
		logic [DW-1:0] re;
		logic [DW-1:0] im;
		logic          truth;
		logic [1:0]    status;
	} alu_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic          s_axis_tvalid = 1'b0;
	logic          s_axis_tready;
	// a_re, a_im, b_re, b_im from the lowest bit up
	logic [63:0]   s_axis_tdata = '0;
	// cmd
	logic [2:0]    s_axis_tuser = cfa_pkg::CMD_ADD;
	logic          m_axis_tvalid;
	logic          m_axis_tready = 1'b0;
	// res_re, res_im from the lowest bit up
	logic [31:0]   m_axis_tdata;
	// truth, status from the lowest bit up
	logic [2:0]    m_axis_tuser;

	alu_res_t pending_results[$];
	int  n_errors = 0;
	int  n_words_in = 0;
	int  n_words_out = 0;
	int  n_div0 = 0;
	int  n_sat = 0;
	int  cyc = 0;
	bit  word_taken = 1'b0;
	bit  idle_on = 1'b1;
	int  src_burst = 0;
	int  sink_burst = 0;

	complex_fixed_point_alu #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	always #5 clk = ~clk;

	// Clamp one part to the signed range; raise the flag when it clips.
	function automatic logic [DW-1:0] clamp_part(input longint v, inout bit clipped);
		if (v > PMAX) begin
			clipped = 1'b1;
			return PMAX[DW-1:0];
		end
		if (v < NMIN) begin
			clipped = 1'b1;
			return NMIN[DW-1:0];
		end
		return v[DW-1:0];
	endfunction

	// Quotient num * 2^FB / den truncated toward zero.
	function automatic longint frac_quot(input longint num, input longint den);
		longint mag;
		mag = ((num < 0) ? -num : num) * (64'sd1 <<< FB) / den;
		return (num < 0) ? -mag : mag;
	endfunction

	// Work out the result word the ALU must give for one operand word.
	function automatic alu_res_t complex_alu_result(input logic [2:0] op,
			input logic [63:0] opnd);
		alu_res_t r;
		longint ar, ai, br, bi, vre, vim, den;
		bit clipped;
		r = '0;
		clipped = 1'b0;
		ar = longint'($signed(opnd[15:0]));
		ai = longint'($signed(opnd[31:16]));
		br = longint'($signed(opnd[47:32]));
		bi = longint'($signed(opnd[63:48]));
		case (op)
			cfa_pkg::CMD_ADD: begin
				vre = ar + br;
				vim = ai + bi;
			end
			cfa_pkg::CMD_SUB: begin
				vre = ar - br;
				vim = ai - bi;
			end
			cfa_pkg::CMD_MUL: begin
				vre = (ar * br - ai * bi) >>> FB;
				vim = (ar * bi + ai * br) >>> FB;
			end
			cfa_pkg::CMD_DIV: begin
				den = br * br + bi * bi;
				if (den == 0) begin
					r.status = cfa_pkg::ST_DIV0;
					return r;
				end
				vre = frac_quot(ar * br + ai * bi, den);
				vim = frac_quot(ai * br - ar * bi, den);
			end
			cfa_pkg::CMD_EQ: begin
				r.truth = (ar == br) && (ai == bi);
				return r;
			end
			cfa_pkg::CMD_NE: begin
				r.truth = (ar != br) || (ai != bi);
				return r;
			end
			default: return r;
		endcase
		r.re = clamp_part(vre, clipped);
		r.im = clamp_part(vim, clipped);
		r.status = clipped ? cfa_pkg::ST_SAT : cfa_pkg::ST_OK;
		return r;
	endfunction

	// Record accepted words and check every result word against the oldest one expected.
	always @(posedge clk) begin
		alu_res_t want, got;
		cyc <= cyc + 1;
		word_taken = s_axis_tvalid && s_axis_tready;
		if (word_taken) begin
			pending_results.push_back(complex_alu_result(s_axis_tuser, s_axis_tdata));
			n_words_in++;
		end
		if (m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tuser[0],
				m_axis_tuser[2:1]};
			n_words_out++;
			if (pending_results.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("unexpected result word re=%h im=%h user=%h",
						got.re, got.im, m_axis_tuser);
			end else begin
				want = pending_results.pop_front();
				if (want.status == cfa_pkg::ST_DIV0) n_div0++;
				if (want.status == cfa_pkg::ST_SAT) n_sat++;
				if (got !== want) begin
					n_errors++;
					if (n_errors <= 10)
						$display("mismatch: exp re=%h im=%h t=%b st=%0d, got re=%h im=%h t=%b st=%0d",
							want.re, want.im, want.truth, want.status,
							got.re, got.im, got.truth, got.status);
				end
			end
		end
		if (cyc > MAX_CYC) begin
			$display("timeout after %0d cycles", cyc);
			$display("TB_ERROR");
			$finish;
		end
	end

	// Sink side: hold off tready in random bursts while idling is on.
	always @(negedge clk) begin
		if (idle_on && sink_burst > 0) begin
			sink_burst--;
			m_axis_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			sink_burst = $urandom_range(0, 15);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Drive one word at the falling edge and hold it until it is taken.
	task automatic send_word(input cfa_pkg::cmd_t op, input logic [15:0] ar, ai, br, bi);
		if (idle_on && src_burst == 0 && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			src_burst = $urandom_range(1, 16);
			repeat (src_burst) @(negedge clk);
			src_burst = 0;
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {bi, br, ai, ar};
		do @(negedge clk); while (!word_taken);
	endtask

	function automatic logic [15:0] rand_part();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($signed($urandom_range(0, 1023)) - 512);
			3: return 16'($signed($urandom_range(0, 64)) - 32);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic test_add_sub_extremes();
		send_word(cfa_pkg::CMD_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
		send_word(cfa_pkg::CMD_ADD, 16'h0100, 16'hff00, 16'h0080, 16'h0040);
		send_word(cfa_pkg::CMD_SUB, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
		send_word(cfa_pkg::CMD_SUB, 16'h8000, 16'h0000, 16'h0001, 16'h0000);
		send_word(cfa_pkg::CMD_SUB, 16'h0000, 16'h0000, 16'h8000, 16'h8000);
	endtask

	task automatic test_multiply();
		send_word(cfa_pkg::CMD_MUL, 16'h0100, 16'h0000, 16'h0100, 16'h0000);
		send_word(cfa_pkg::CMD_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_word(cfa_pkg::CMD_MUL, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff);
		// negative product that must round toward minus infinity
		send_word(cfa_pkg::CMD_MUL, 16'hffff, 16'h0000, 16'h0001, 16'h0000);
		send_word(cfa_pkg::CMD_MUL, 16'h0180, 16'hfe80, 16'hff40, 16'h0020);
	endtask

	task automatic test_divide();
		send_word(cfa_pkg::CMD_DIV, 16'h0100, 16'h0100, 16'h0000, 16'h0000);
		send_word(cfa_pkg::CMD_DIV, 16'h7fff, 16'h8000, 16'h0000, 16'h0000);
		send_word(cfa_pkg::CMD_DIV, 16'h0100, 16'h0000, 16'h0100, 16'h0000);
		send_word(cfa_pkg::CMD_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000);
		send_word(cfa_pkg::CMD_DIV, 16'hff01, 16'h0003, 16'h0300, 16'hfd00);
		send_word(cfa_pkg::CMD_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
	endtask

	task automatic test_compare();
		send_word(cfa_pkg::CMD_EQ, 16'h1234, 16'h8000, 16'h1234, 16'h8000);
		send_word(cfa_pkg::CMD_EQ, 16'h1234, 16'h8000, 16'h1234, 16'h7fff);
		send_word(cfa_pkg::CMD_NE, 16'h1234, 16'h8000, 16'h1234, 16'h8000);
		// only one part differs: not-equal must still hold
		send_word(cfa_pkg::CMD_NE, 16'h1234, 16'h5678, 16'h1235, 16'h5678);
		send_word(cfa_pkg::CMD_NE, 16'h0001, 16'h0002, 16'h0003, 16'h0004);
	endtask

	task automatic test_random(input int n_words);
		logic [15:0] ar, ai, br, bi;
		cfa_pkg::cmd_t op;
		repeat (n_words) begin
			op = cfa_pkg::cmd_t'($urandom_range(cfa_pkg::CMD_ADD, cfa_pkg::CMD_NE));
			ar = rand_part();
			ai = rand_part();
			br = rand_part();
			bi = rand_part();
			if (op == cfa_pkg::CMD_DIV && $urandom_range(0, 9) == 0) begin
				br = '0;
				bi = '0;
			end
			if ((op == cfa_pkg::CMD_EQ || op == cfa_pkg::CMD_NE) &&
					$urandom_range(0, 2) != 0) begin
				br = ar;
				bi = $urandom_range(0, 1) ? ai : ai ^ (16'h1 << $urandom_range(0, 15));
			end
			send_word(op, ar, ai, br, bi);
		end
	endtask

	initial begin
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_add_sub_extremes();
		test_multiply();
		test_divide();
		test_compare();
		test_random(330);
		idle_on = 1'b0;
		test_random(100);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		$display("covered %0d words in, %0d out; %0d saturated, %0d divide-by-zero",
			n_words_in, n_words_out, n_sat, n_div0);
		$display("mismatches seen: %0d", n_errors);
		if (n_errors == 0 && pending_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
